### rtl/hfpd_pkg.sv
// shared types and constants for the haptic force to pwm duty block
`timescale 1ns / 1ps
`default_nettype none
package hfpd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_N    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_M    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_MULT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd5;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] COUNT_BYTE = 2'd1;
  localparam logic [1:0] COUNT_WORD = 2'd2;

  localparam logic [7:0]  FULL_FORCE     = 8'd127;
  localparam logic [7:0]  DRV_ON         = 8'h88;
  localparam logic [7:0]  DRV_OFF        = 8'h08;
  localparam logic [6:0]  STRENGTH_RESET = 7'd100;
  localparam logic [6:0]  PCT_SCALE      = 7'd100;
  // floor(2^24 / 100), quotient estimate is exact or one low
  localparam logic [17:0] RECIP_100      = 18'd167772;
  localparam int          RECIP_SHIFT    = 24;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic       fail;
    logic       zero;
    logic [7:0] level;
  } item_t;

  typedef struct packed {
    logic [15:0] clock_n;
    logic [15:0] clock_m;
    logic [15:0] clock_d_base;
    logic [15:0] force_mult;
    logic [6:0]  strength;
    logic [15:0] min_duty;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SCALE,
    S_RECIP,
    S_FIX,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/hfpd_front.sv
// front end: sample depth check and force transform
`timescale 1ns / 1ps
`default_nettype none
module hfpd_front
  import hfpd_pkg::*;
(
  input  wire logic [1:0]  kind,
  input  wire logic [1:0]  byte_count,
  input  wire logic [15:0] sample,
  output item_t            item
);

  logic [7:0] raw;
  logic       bad;

  always_comb begin
    unique case (kind)
      KIND_BYTE: begin
        raw = sample[7:0];
        bad = (byte_count != COUNT_BYTE);
      end
      KIND_WORD: begin
        raw = sample[15:8];
        bad = (byte_count != COUNT_WORD);
      end
      default: begin
        raw = '0;
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    item.fail = bad;
    item.zero = (raw == '0);
    if (!raw[7] && raw != '0) begin
      item.level = FULL_FORCE - raw;
    end else begin
      item.level = raw;
    end
  end

endmodule
`default_nettype wire

### rtl/hfpd_queue.sv
// short queue between front end and duty engine
`timescale 1ns / 1ps
`default_nettype none
module hfpd_queue
  import hfpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       ready,
  output logic       valid,
  output item_t      head,
  input  wire logic  pop
);

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   fill;

  assign ready = (fill != Q_DEPTH[Q_PTR_W:0]);
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/hfpd_back.sv
// duty engine: state, shared multiplier sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module hfpd_back
  import hfpd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire item_t  q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        status,
  output logic        duty_written,
  output logic [15:0] duty_word,
  output logic [15:0] period_word,
  output logic        clock_on,
  output logic        amp_on,
  output logic [7:0]  driver_ctrl
);

  state_t state, state_next;
  item_t  cur;

  logic        amp_en;
  logic        clk_en;
  logic [7:0]  prev;
  logic [15:0] last_duty;

  logic signed [24:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [43:0] mul_p;
  logic signed [43:0] mul_q;

  logic signed [15:0] prod;
  logic [23:0]        mag;
  logic               neg;
  logic signed [17:0] scaled;

  logic               slot_free;
  logic               needs_calc;
  logic               pos;
  logic signed [15:0] prod_now;
  logic signed [17:0] base;
  logic signed [24:0] x_val;
  logic signed [24:0] x_abs;
  logic [16:0]        q_est;
  logic [23:0]        q_times;
  logic [23:0]        rem;
  logic [16:0]        quo;
  logic signed [17:0] scaled_now;
  logic signed [18:0] v_pos;
  logic signed [18:0] v_neg;
  logic signed [18:0] gap;
  logic signed [18:0] v_fin;
  logic [15:0]        duty_now;

  logic load;
  logic load_fail;
  logic upd_zero;
  logic upd_calc;
  logic amp_after;
  logic clk_after;

  assign slot_free  = !out_valid || out_ready;
  assign needs_calc = !q_item.fail && !q_item.zero && (q_item.level != prev);
  assign pos        = !cur.level[7] && (cur.level != '0);

  // datapath between multiplier passes
  always_comb begin
    prod_now = mul_q[23:8];
    if (pos) begin
      base = $signed({2'b00, cfg.clock_n}) - 18'(prod_now);
    end else begin
      base = $signed({2'b00, cfg.clock_n});
    end
    x_val = mul_q[24:0];
    x_abs = x_val[24] ? -x_val : x_val;
    q_est   = mul_q[RECIP_SHIFT +: 17];
    q_times = 24'(q_est * PCT_SCALE);
    rem     = mag - q_times;
    quo     = (rem >= 24'(PCT_SCALE)) ? q_est + 17'd1 : q_est;
    scaled_now = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  // final clamp on either branch
  always_comb begin
    v_pos = 19'(scaled);
    if (v_pos < $signed({3'b000, cfg.min_duty})) begin
      v_pos = $signed({3'b000, cfg.min_duty});
    end
    v_neg = 19'(prod) + $signed({3'b000, cfg.clock_d_base});
    gap   = $signed({3'b000, cfg.clock_n}) - v_neg;
    if (gap > 19'(scaled)) begin
      v_neg = $signed({3'b000, cfg.clock_n}) - 19'(scaled);
    end
    v_fin    = pos ? v_pos : v_neg;
    duty_now = ~{v_fin[14:0], 1'b0};
  end

  always_comb begin
    unique case (state)
      S_PROD: begin
        mul_a = 25'($signed(cur.level));
        mul_b = $signed({3'b000, cfg.force_mult});
      end
      S_SCALE: begin
        mul_a = 25'(base);
        mul_b = $signed({12'd0, cfg.strength});
      end
      S_RECIP: begin
        mul_a = $signed({1'b0, x_abs[23:0]});
        mul_b = $signed({1'b0, RECIP_100});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    load_fail  = 1'b0;
    upd_zero   = 1'b0;
    upd_calc   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          priority if (needs_calc) begin
            q_pop      = 1'b1;
            state_next = S_PROD;
          end else if (slot_free) begin
            q_pop     = 1'b1;
            load      = 1'b1;
            load_fail = q_item.fail;
            upd_zero  = !q_item.fail && q_item.zero;
          end else begin
            q_pop = 1'b0;
          end
        end
      end
      S_PROD:  state_next = S_SCALE;
      S_SCALE: state_next = S_RECIP;
      S_RECIP: state_next = S_FIX;
      S_FIX:   state_next = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          upd_calc   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    amp_after = upd_calc ? 1'b1 : (upd_zero ? 1'b0 : amp_en);
    clk_after = upd_calc ? 1'b1 : (upd_zero ? 1'b0 : clk_en);
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_p;
    if (state == S_IDLE && q_pop) begin
      cur <= q_item;
    end
    if (state == S_SCALE) begin
      prod <= prod_now;
    end
    if (state == S_RECIP) begin
      mag <= x_abs[23:0];
      neg <= x_val[24];
    end
    if (state == S_FIX) begin
      scaled <= scaled_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_en    <= 1'b0;
      clk_en    <= 1'b0;
      prev      <= '0;
      last_duty <= '0;
    end else begin
      amp_en <= amp_after;
      clk_en <= clk_after;
      if (upd_zero) begin
        prev <= '0;
      end else if (upd_calc) begin
        prev      <= cur.level;
        last_duty <= duty_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= load_fail;
      duty_written <= upd_calc;
      duty_word    <= upd_calc ? duty_now : last_duty;
      period_word  <= ~(cfg.clock_n - cfg.clock_m);
      clock_on     <= clk_after;
      amp_on       <= amp_after;
      driver_ctrl  <= amp_after ? DRV_ON : DRV_OFF;
    end
  end

endmodule
`default_nettype wire

### rtl/haptic_force_to_pwm_duty.sv
// top level: configuration registers, front end, queue and duty engine
// flow: an input transfer enters the queue; an item that needs no new duty is then loaded
//   into the result register; otherwise it passes multiply, scale, reciprocal, fix, clamp
// throughput: one item per cycle without a new duty while the output accepts; with one,
//   the single shared multiplier holds off further items; a two-entry queue decouples
// reset: synchronous, clears queue, engine state, amplifier and clock flags, previous force
//   and last duty word; registers return to zero and strength to 100
`timescale 1ns / 1ps
`default_nettype none
module haptic_force_to_pwm_duty
  import hfpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // byte_count[1:0], sample[17:2]
  input  wire logic [1:0]            s_axis_tuser,  // kind[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status[0], duty_written[1], duty_word[17:2], period_word[33:18],
  // clock_on[34], amp_on[35], driver_ctrl[43:36]
  output logic [47:0]                m_axis_tdata
);

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  q_ready;
  logic  q_valid;
  logic  q_pop;

  logic        status;
  logic        duty_written;
  logic [15:0] duty_word;
  logic [15:0] period_word;
  logic        clock_on;
  logic        amp_on;
  logic [7:0]  driver_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_n      <= '0;
      cfg.clock_m      <= '0;
      cfg.clock_d_base <= '0;
      cfg.force_mult   <= '0;
      cfg.strength     <= STRENGTH_RESET;
      cfg.min_duty     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_N:    cfg.clock_n      <= cfg_data;
        REG_CLOCK_M:    cfg.clock_m      <= cfg_data;
        REG_CLOCK_D:    cfg.clock_d_base <= cfg_data;
        REG_FORCE_MULT: cfg.force_mult   <= cfg_data;
        REG_STRENGTH:   cfg.strength     <= cfg_data[6:0];
        REG_MIN_DUTY:   cfg.min_duty     <= cfg_data;
        default: ;
      endcase
    end
  end

  hfpd_front u_front (
    .kind       (s_axis_tuser),
    .byte_count (s_axis_tdata[1:0]),
    .sample     (s_axis_tdata[17:2]),
    .item       (front_item)
  );

  assign s_axis_tready = q_ready;

  hfpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && q_ready),
    .push_item (front_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (head_item),
    .pop       (q_pop)
  );

  hfpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .status       (status),
    .duty_written (duty_written),
    .duty_word    (duty_word),
    .period_word  (period_word),
    .clock_on     (clock_on),
    .amp_on       (amp_on),
    .driver_ctrl  (driver_ctrl)
  );

  assign m_axis_tdata = {4'b0000, driver_ctrl, amp_on, clock_on, period_word, duty_word,
                         duty_written, status};

endmodule
`default_nettype wire

### dv/haptic_force_to_pwm_duty_tb.sv
// testbench for haptic_force_to_pwm_duty: stream stimulus, duty prediction and result checks
`timescale 1ns / 1ps
module haptic_force_to_pwm_duty_tb
  import hfpd_pkg::*;
();

  localparam logic [1:0] KIND_BAD_LO = 2'd2;
  localparam logic [1:0] KIND_BAD_HI = 2'd3;
  localparam logic [1:0] COUNT_NONE  = 2'd0;
  localparam logic [1:0] COUNT_THREE = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 195;

  typedef struct packed {
    logic [7:0]  driver_ctrl;
    logic        amp_on;
    logic        clock_on;
    logic [15:0] period_word;
    logic [15:0] duty_word;
    logic        duty_written;
    logic        status;
  } duty_result_t;

  class duty_tracker;
    cfg_t         regs;
    bit           amp_en;
    bit           clk_en;
    int           prev_force;
    logic [15:0]  last_duty;
    duty_result_t due_q[$];
    int           errors;
    int           seen;

    function new();
      regs = '0;
      regs.strength = STRENGTH_RESET;
      amp_en = 1'b0;
      clk_en = 1'b0;
      prev_force = 0;
      last_duty = '0;
      errors = 0;
      seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_CLOCK_N:    regs.clock_n = val;
        REG_CLOCK_M:    regs.clock_m = val;
        REG_CLOCK_D:    regs.clock_d_base = val;
        REG_FORCE_MULT: regs.force_mult = val;
        REG_STRENGTH:   regs.strength = val[6:0];
        REG_MIN_DUTY:   regs.min_duty = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] duty_for(int t);
      longint prod, v, cap, n, pct, s;
      n = regs.clock_n;
      s = regs.strength;
      pct = PCT_SCALE;
      prod = (longint'(t) * longint'(regs.force_mult)) >>> 8;
      if (t > 0) begin
        v = n - prod;
        v = (v * s) / pct;
        if (v < longint'(regs.min_duty)) v = regs.min_duty;
      end else begin
        cap = (n * s) / pct;
        v = prod + longint'(regs.clock_d_base);
        if (n - v > cap) v = n - cap;
      end
      return ~{v[14:0], 1'b0};
    endfunction

    function void take_force(logic [1:0] kind, logic [1:0] cnt, logic [15:0] smp);
      duty_result_t exp_r;
      logic [7:0] force_byte;
      bit fail, written;
      int f, full;
      full = FULL_FORCE;
      fail = 1'b1;
      written = 1'b0;
      force_byte = '0;
      if (kind == KIND_BYTE) begin
        force_byte = smp[7:0];
        fail = (cnt != COUNT_BYTE);
      end else if (kind == KIND_WORD) begin
        force_byte = smp[15:8];
        fail = (cnt != COUNT_WORD);
      end
      if (!fail) begin
        f = $signed(force_byte);
        if (f == 0) begin
          amp_en = 1'b0;
          clk_en = 1'b0;
          prev_force = 0;
        end else begin
          if (f > 0) f = full - f;
          if (f != prev_force) begin
            last_duty = duty_for(f);
            written = 1'b1;
            amp_en = 1'b1;
            clk_en = 1'b1;
            prev_force = f;
          end
        end
      end
      exp_r.status = fail;
      exp_r.duty_written = written;
      exp_r.duty_word = last_duty;
      exp_r.period_word = ~(regs.clock_n - regs.clock_m);
      exp_r.clock_on = clk_en;
      exp_r.amp_on = amp_en;
      exp_r.driver_ctrl = amp_en ? DRV_ON : DRV_OFF;
      due_q.push_back(exp_r);
    endfunction

    function void check_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("result %0d, %s: expected 0x%0h, got 0x%0h", seen, fname, want, got);
      end
    endfunction

    function void match_result(logic [47:0] data);
      duty_result_t got, want;
      got = data[43:0];
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result 0x%0h with nothing expected", data);
      end else begin
        want = due_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("duty_written", want.duty_written, got.duty_written);
        check_field("duty_word", want.duty_word, got.duty_word);
        check_field("period_word", want.period_word, got.period_word);
        check_field("clock_on", want.clock_on, got.clock_on);
        check_field("amp_on", want.amp_on, got.amp_on);
        check_field("driver_ctrl", want.driver_ctrl, got.driver_ctrl);
      end
      seen++;
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // byte_count[1:0], sample[17:2]
  logic [1:0]            s_axis_tuser = '0;  // kind[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status[0], duty_written[1], duty_word[17:2], period_word[33:18],
  // clock_on[34], amp_on[35], driver_ctrl[43:36]
  logic [47:0]           m_axis_tdata;

  duty_tracker tracker;
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [7:0]  last_force_byte = '0;
  int          stall_cycles = 0;

  haptic_force_to_pwm_duty dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.set_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_force(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[17:2]);
      if (m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("haptic_force_to_pwm_duty_tb: done, errors");
      $finish;
    end
  end

  initial begin : result_sink
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) idle_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [1:0] cnt,
                           input logic [15:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, smp, cnt};
    s_axis_tuser <= kind;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
  endtask

  task automatic send_random_item();
    logic [1:0] kind, cnt;
    logic [15:0] smp;
    logic [7:0] b;
    int r;
    smp = 16'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      kind = 2'($urandom_range(0, 3));
      cnt = 2'($urandom_range(0, 3));
    end else begin
      kind = $urandom_range(0, 1) ? KIND_WORD : KIND_BYTE;
      cnt = (kind == KIND_BYTE) ? COUNT_BYTE : COUNT_WORD;
      r = $urandom_range(0, 99);
      if (r < 10) b = 8'h00;
      else if (r < 22) b = last_force_byte;
      else if (r < 28) b = FULL_FORCE;
      else if (r < 32) b = 8'h80;
      else b = 8'($urandom);
      last_force_byte = b;
      if (kind == KIND_BYTE) smp[7:0] = b;
      else smp[15:8] = b;
    end
    send_item(kind, cnt, smp);
  endtask

  task automatic drain();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_regs(input logic [15:0] n, input logic [15:0] m, input logic [15:0] d,
                           input logic [15:0] mult, input logic [6:0] s,
                           input logic [15:0] mn);
    drain();
    repeat (12) @(posedge clk);
    write_reg(REG_CLOCK_N, n);
    write_reg(REG_CLOCK_M, m);
    write_reg(REG_CLOCK_D, d);
    write_reg(REG_FORCE_MULT, mult);
    write_reg(REG_STRENGTH, {9'd0, s});
    write_reg(REG_MIN_DUTY, mn);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int ph, i;
    logic [15:0] n;
    logic [6:0] s;
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset register values
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0040);
    send_item(KIND_WORD, COUNT_WORD, 16'hC000);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0000);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h007F);

    load_regs(16'd1000, 16'd200, 16'd300, 16'd384, 7'd75, 16'd100);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0005);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0005);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h007F);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0080);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h00FF);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0000);
    send_item(KIND_BYTE, COUNT_BYTE, 16'hFF00);
    send_item(KIND_WORD, COUNT_WORD, 16'h7FFF);
    send_item(KIND_WORD, COUNT_WORD, 16'h8000);
    send_item(KIND_WORD, COUNT_WORD, 16'h0100);
    send_item(KIND_WORD, COUNT_WORD, 16'h00FF);
    send_item(KIND_BYTE, COUNT_NONE, 16'h0011);
    send_item(KIND_BYTE, COUNT_WORD, 16'h0022);
    send_item(KIND_BYTE, COUNT_THREE, 16'hFFFF);
    send_item(KIND_WORD, COUNT_BYTE, 16'h3300);
    send_item(KIND_WORD, COUNT_NONE, 16'h4400);
    send_item(KIND_WORD, COUNT_THREE, 16'h8080);
    send_item(KIND_BAD_LO, COUNT_BYTE, 16'h0001);
    send_item(KIND_BAD_HI, COUNT_WORD, 16'h0100);
    send_item(KIND_BAD_LO, COUNT_NONE, 16'hFFFF);
    send_item(KIND_BAD_HI, COUNT_THREE, 16'h1234);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h0001);
    send_item(KIND_BYTE, COUNT_BYTE, 16'h007E);
    send_item(KIND_WORD, COUNT_WORD, 16'hC3A5);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF);
        1: load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 16'h0000);
        2: load_regs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100, 16'h0000);
        default: begin
          n = 16'($urandom);
          s = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
          load_regs(n, 16'($urandom), 16'($urandom), 16'($urandom), s,
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, n)));
        end
      endcase
      no_idle = (ph == 3);
      if (ph == 4) long_hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == 100) drain();
        send_random_item();
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("haptic_force_to_pwm_duty_tb: done, clean");
    else
      $display("haptic_force_to_pwm_duty_tb: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/hfpd_pkg.sv
rtl/hfpd_front.sv
rtl/hfpd_queue.sv
rtl/hfpd_back.sv
rtl/haptic_force_to_pwm_duty.sv
dv/haptic_force_to_pwm_duty_tb.sv
